// ===== hdl/bba_pkg.sv =====
package bba_pkg;

  // Field widths of the request and response items
  localparam int SIZE_W        = 27;
  localparam int OFF_FIELD_W   = 10;
  localparam int LEVEL_FIELD_W = 4;
  localparam int SHIFT_W       = 5;
  localparam int LG_W          = 6;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd4;

  // Request kinds
  localparam logic [1:0] KIND_ALLOC      = 2'd0;
  localparam logic [1:0] KIND_FREE_SPLIT = 2'd1;
  localparam logic [1:0] KIND_FREE_SIZE  = 2'd2;

  // Response status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_SIZE = 2'd2;

  // Register index of min_block_shift
  localparam logic REG_MIN_SHIFT = 1'b0;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_A_SCAN,
    ST_U_RD,
    ST_U_WR,
    ST_SPLIT,
    ST_P_WR1,
    ST_P_WR2,
    ST_NEXT_L,
    ST_STEP,
    ST_F1_RD,
    ST_F1_CHK,
    ST_MERGE_RD,
    ST_MERGE_CHK,
    ST_MERGE_CLR,
    ST_DONE
  } st_t;

  // Return point after an unlink or push sequence
  typedef enum logic [2:0] {
    PH_SPLIT_U,
    PH_MERGE_U,
    PH_PUSH_R,
    PH_PUSH_L,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    st_t  op;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       oversize;
    logic       head_ok;
    logic       j_zero;
    logic       j_lt_t;
    logic       lvl_zero;
    logic       split_bit;
    logic       free_bit;
    logic [1:0] kind;
  } sts_t;

  // Position of the highest set bit, zero for zero
  function automatic logic [SHIFT_W-1:0] flog2(input logic [SIZE_W-1:0] v);
    logic [SHIFT_W-1:0] r;
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) r = SHIFT_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== hdl/bba_ctrl.sv =====
module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  st_t    state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Hold state, phase and output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ph_r        <= PH_SPLIT_U;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence the request through the datapath steps
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd.op    = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.kind)
          KIND_ALLOC:      state_nxt = sts.oversize ? ST_DONE : ST_A_SCAN;
          KIND_FREE_SPLIT: state_nxt = ST_F1_RD;
          KIND_FREE_SIZE:  state_nxt = sts.oversize ? ST_DONE : ST_MERGE_RD;
          default:         state_nxt = ST_DONE;
        endcase
      end
      ST_A_SCAN: begin
        if (sts.head_ok) begin
          state_nxt = ST_U_RD;
          ph_nxt    = PH_SPLIT_U;
        end else if (sts.j_zero) begin
          state_nxt = ST_DONE;
        end
      end
      ST_U_RD: state_nxt = ST_U_WR;
      ST_U_WR: state_nxt = (ph_r == PH_MERGE_U) ? ST_MERGE_CLR : ST_SPLIT;
      ST_SPLIT: begin
        if (sts.j_lt_t) begin
          state_nxt = ST_P_WR1;
          ph_nxt    = PH_PUSH_R;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_P_WR1: state_nxt = ST_P_WR2;
      ST_P_WR2: begin
        case (ph_r)
          PH_PUSH_R: state_nxt = ST_NEXT_L;
          PH_PUSH_L: state_nxt = ST_STEP;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_NEXT_L: begin
        state_nxt = ST_P_WR1;
        ph_nxt    = PH_PUSH_L;
      end
      ST_STEP: begin
        state_nxt = ST_U_RD;
        ph_nxt    = PH_SPLIT_U;
      end
      ST_F1_RD:  state_nxt = sts.lvl_zero ? ST_MERGE_RD : ST_F1_CHK;
      ST_F1_CHK: state_nxt = sts.split_bit ? ST_MERGE_RD : ST_F1_RD;
      ST_MERGE_RD: begin
        if (sts.lvl_zero) begin
          state_nxt = ST_P_WR1;
          ph_nxt    = PH_FINAL;
        end else begin
          state_nxt = ST_MERGE_CHK;
        end
      end
      ST_MERGE_CHK: begin
        if (sts.free_bit) begin
          state_nxt = ST_U_RD;
          ph_nxt    = PH_MERGE_U;
        end else begin
          state_nxt = ST_P_WR1;
          ph_nxt    = PH_FINAL;
        end
      end
      ST_MERGE_CLR: state_nxt = ST_MERGE_RD;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Fill the output slot on emit, drain it on take
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/bba_datapath.sv =====
module bba_datapath
  import bba_pkg::*;
#(
  parameter int TREE_LEVELS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [SHIFT_W-1:0]       min_shift,
  input  logic [1:0]               in_kind,
  input  logic [SIZE_W-1:0]        in_size,
  input  logic [OFF_FIELD_W-1:0]   in_offset,
  output logic [1:0]               out_status,
  output logic [OFF_FIELD_W-1:0]   out_granted,
  output logic [LEVEL_FIELD_W-1:0] out_level
);

  localparam int L     = TREE_LEVELS;
  localparam int NW    = L + 1;
  localparam int LW    = $clog2(L + 1);
  localparam int ARENA = 1 << L;
  localparam logic [NW-1:0] NIL = NW'(ARENA);

  // Tree node index of a block start at a level
  function automatic logic [NW-1:0] node(input logic [L-1:0] o, input logic [LW-1:0] lv);
    node = (NW'(1) << lv) + (NW'(o) >> (LW'(L) - lv)) - NW'(1);
  endfunction

  // Block span at a level, in minimum blocks
  function automatic logic [NW-1:0] span(input logic [LW-1:0] lv);
    span = NW'(1) << (LW'(L) - lv);
  endfunction

  function automatic logic [L-1:0] align(input logic [L-1:0] o, input logic [LW-1:0] lv);
    align = o & ~L'(span(lv) - NW'(1));
  endfunction

  // Request and walk registers
  logic [1:0]        kind_r;
  logic [SIZE_W-1:0] size_r;
  logic [L-1:0]      off_r, b_r, tgt_off_r;
  logic [LW-1:0]     t_r, j_r, lvl_r, tgt_lvl_r, lv_r;
  logic [NW-1:0]     h_r;
  logic [1:0]        stat_r;
  logic [L-1:0]      gr_r;
  logic [NW-1:0]     clr_r;
  logic [NW-1:0]     head_r [0:L];

  // Output payload
  logic [1:0]               o_stat_r;
  logic [OFF_FIELD_W-1:0]   o_gr_r;
  logic [LEVEL_FIELD_W-1:0] o_lv_r;

  // Memories and their read data
  logic [NW-1:0] nx_mem [0:ARENA-1];
  logic [NW-1:0] pv_mem [0:ARENA-1];
  logic          fr_mem [0:2*ARENA-1];
  logic          sp_mem [0:ARENA-1];
  logic [NW-1:0] nx_rd_r, pv_rd_r;
  logic          fr_rd_r, sp_rd_r;

  logic          nx_we, pv_we, fr_we, sp_we;
  logic [L-1:0]  nx_wa, pv_wa, sp_wa;
  logic [NW-1:0] fr_wa, fr_ra, nx_wd, pv_wd;
  logic [L-1:0]  sp_ra;
  logic          fr_wd, sp_wd;

  // Size decode
  logic [LG_W-1:0]    c_up, lg_a, lg_f;
  logic [SHIFT_W-1:0] fl;
  logic               a_over, f_ok, f_bad;
  logic [LW-1:0]      a_lvl, f_lvl;

  always_comb begin
    c_up   = (size_r <= SIZE_W'(1)) ? '0
           : LG_W'(flog2(size_r - SIZE_W'(1))) + LG_W'(1);
    lg_a   = (c_up > LG_W'(min_shift)) ? c_up - LG_W'(min_shift) : '0;
    a_over = lg_a > LG_W'(L);
    a_lvl  = LW'(L) - LW'(lg_a);
    fl     = flog2(size_r);
    f_ok   = (size_r != '0) && (fl >= min_shift);
    lg_f   = LG_W'(fl) - LG_W'(min_shift);
    f_bad  = !f_ok || (lg_f > LG_W'(L));
    f_lvl  = LW'(L) - LW'(lg_f);
  end

  // Head list read, link normalization
  logic [LW-1:0] hd_ra;
  logic [NW-1:0] hd_rd, nx_n, pv_n;
  logic          nx_ok, pv_ok, head_match, h_ok, h_r_ok;
  logic [L-1:0]  buddy, left;

  assign hd_ra      = (cmd.op == ST_A_SCAN) ? j_r : tgt_lvl_r;
  assign hd_rd      = head_r[hd_ra];
  assign h_ok       = !hd_rd[L];
  assign h_r_ok     = !h_r[L];
  assign nx_ok      = !nx_rd_r[L];
  assign pv_ok      = !pv_rd_r[L];
  assign nx_n       = nx_ok ? nx_rd_r : NIL;
  assign pv_n       = pv_ok ? pv_rd_r : NIL;
  assign head_match = (hd_rd == {1'b0, tgt_off_r});
  assign buddy      = off_r ^ L'(span(lvl_r));
  assign left       = off_r & ~L'(span(lvl_r));
  assign fr_ra      = node(buddy, lvl_r);
  assign sp_ra      = L'(node(off_r, lvl_r - LW'(1)));

  // Drive memory write ports per step
  always_comb begin
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    fr_we = 1'b0; fr_wa = '0; fr_wd = 1'b0;
    sp_we = 1'b0; sp_wa = '0; sp_wd = 1'b0;
    case (cmd.op)
      ST_CLEAR: begin
        fr_we = 1'b1; fr_wa = clr_r;
        sp_we = 1'b1; sp_wa = clr_r[L-1:0];
        nx_we = 1'b1; nx_wd = NIL;
        pv_we = 1'b1; pv_wd = NIL;
      end
      ST_U_WR: begin
        fr_we = (tgt_lvl_r != '0);
        fr_wa = node(tgt_off_r, tgt_lvl_r);
        if (!head_match && pv_ok) begin
          nx_we = 1'b1; nx_wa = pv_n[L-1:0]; nx_wd = nx_n;
        end
        if (nx_ok) begin
          pv_we = 1'b1; pv_wa = nx_n[L-1:0]; pv_wd = pv_n;
        end
      end
      ST_P_WR1: begin
        fr_we = (tgt_lvl_r != '0);
        fr_wa = node(tgt_off_r, tgt_lvl_r);
        fr_wd = 1'b1;
        nx_we = 1'b1; nx_wa = tgt_off_r; nx_wd = h_ok ? hd_rd : NIL;
        pv_we = 1'b1; pv_wa = tgt_off_r; pv_wd = NIL;
      end
      ST_P_WR2: begin
        pv_we = h_r_ok; pv_wa = h_r[L-1:0]; pv_wd = {1'b0, tgt_off_r};
      end
      ST_SPLIT: begin
        sp_we = (j_r < t_r); sp_wa = L'(node(b_r, j_r)); sp_wd = 1'b1;
      end
      ST_MERGE_CLR: begin
        sp_we = 1'b1; sp_wa = L'(node(left, lvl_r - LW'(1)));
      end
      default: ;
    endcase
  end

  // Link, free and split memories with registered reads
  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd_r <= nx_mem[tgt_off_r];
  end

  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd_r <= pv_mem[tgt_off_r];
  end

  always_ff @(posedge clk) begin
    if (fr_we) fr_mem[fr_wa] <= fr_wd;
    fr_rd_r <= fr_mem[fr_ra];
  end

  always_ff @(posedge clk) begin
    if (sp_we) sp_mem[sp_wa] <= sp_wd;
    sp_rd_r <= sp_mem[sp_ra];
  end

  // Advance clearing sweep, keep list heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      for (int i = 0; i <= L; i++) head_r[i] <= (i == 0) ? '0 : NIL;
    end else begin
      if (cmd.op == ST_CLEAR) clr_r <= clr_r + NW'(1);
      if (cmd.op == ST_U_WR && head_match) head_r[tgt_lvl_r] <= nx_n;
      if (cmd.op == ST_P_WR1) head_r[tgt_lvl_r] <= {1'b0, tgt_off_r};
    end
  end

  // Walk registers per step
  always_ff @(posedge clk) begin
    case (cmd.op)
      ST_IDLE: begin
        if (cmd.load) begin
          kind_r <= in_kind;
          size_r <= in_size;
          off_r  <= L'(in_offset);
          stat_r <= STAT_DONE;
          gr_r   <= '0;
          lv_r   <= '0;
        end
      end
      ST_DECODE: begin
        case (kind_r)
          KIND_ALLOC: begin
            if (a_over) stat_r <= STAT_SIZE;
            else begin
              t_r <= a_lvl;
              j_r <= a_lvl;
            end
          end
          KIND_FREE_SPLIT: lvl_r <= LW'(L);
          KIND_FREE_SIZE: begin
            if (f_bad) stat_r <= STAT_SIZE;
            else begin
              lv_r  <= f_lvl;
              lvl_r <= f_lvl;
              off_r <= align(off_r, f_lvl);
            end
          end
          default: ;
        endcase
      end
      ST_A_SCAN: begin
        if (h_ok) begin
          b_r       <= hd_rd[L-1:0];
          tgt_off_r <= hd_rd[L-1:0];
          tgt_lvl_r <= j_r;
        end else if (j_r == '0) begin
          stat_r <= STAT_OOM;
          lv_r   <= t_r;
        end else begin
          j_r <= j_r - LW'(1);
        end
      end
      ST_SPLIT: begin
        if (j_r < t_r) begin
          tgt_off_r <= b_r + L'(span(j_r + LW'(1)));
          tgt_lvl_r <= j_r + LW'(1);
        end else begin
          gr_r <= b_r;
          lv_r <= t_r;
        end
      end
      ST_P_WR1:  h_r       <= hd_rd;
      ST_NEXT_L: tgt_off_r <= b_r;
      ST_STEP:   j_r       <= j_r + LW'(1);
      ST_F1_RD: begin
        if (lvl_r == '0) begin
          lv_r  <= '0;
          off_r <= align(off_r, '0);
        end
      end
      ST_F1_CHK: begin
        if (sp_rd_r) begin
          lv_r  <= lvl_r;
          off_r <= align(off_r, lvl_r);
        end else begin
          lvl_r <= lvl_r - LW'(1);
        end
      end
      ST_MERGE_RD: begin
        tgt_off_r <= off_r;
        tgt_lvl_r <= lvl_r;
      end
      ST_MERGE_CHK: begin
        tgt_off_r <= fr_rd_r ? buddy : off_r;
        tgt_lvl_r <= lvl_r;
      end
      ST_MERGE_CLR: begin
        off_r <= left;
        lvl_r <= lvl_r - LW'(1);
      end
      default: ;
    endcase
  end

  // Load the response slot
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_stat_r <= stat_r;
      o_gr_r   <= OFF_FIELD_W'(gr_r);
      o_lv_r   <= LEVEL_FIELD_W'(lv_r);
    end
  end

  assign out_status  = o_stat_r;
  assign out_granted = o_gr_r;
  assign out_level   = o_lv_r;

  always_comb begin
    sts.clr_last  = &clr_r;
    sts.oversize  = (kind_r == KIND_ALLOC) ? a_over : f_bad;
    sts.head_ok   = h_ok;
    sts.j_zero    = (j_r == '0);
    sts.j_lt_t    = (j_r < t_r);
    sts.lvl_zero  = (lvl_r == '0);
    sts.split_bit = sp_rd_r;
    sts.free_bit  = fr_rd_r;
    sts.kind      = kind_r;
  end

endmodule

// ===== hdl/buddy_block_allocator.sv =====
// Channel  | Direction | Ports                      | Item
// in_      | slave     | in_tvalid/tready/tdata/user| one alloc or free request
// out_     | master    | out_tvalid/tready/tdata/user| one response per request
// cfg_     | APB slave | psel/penable/pwrite/paddr  | min_block_shift at 0x0
//
// One request at a time. After accept and decode, an alloc scans one level list per cycle,
// unlinks the found block and splits it level by level, pushing both halves at each level;
// a free-split request walks split bits level by level, then a free merges level by level,
// checks the last buddy (not at the root) and pushes the result; then the response is loaded.
// The walk over tree levels with memory reads and writes sets the time a request takes.
// After reset a clearing pass wipes the free and split bits;
// no request is accepted then. A new request is taken while a response waits; the load
// of the next response holds until the waiting one is taken.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int TREE_LEVELS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // size_bytes[26:0], block_offset[36:27]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // granted_offset[9:0], block_level[13:10]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cmd_t cmd;
  sts_t sts;
  logic [SHIFT_W-1:0]       shift_r;
  logic [OFF_FIELD_W-1:0]   granted;
  logic [LEVEL_FIELD_W-1:0] level;

  // Hold the minimum block shift
  always_ff @(posedge clk) begin
    if (!rst_n) shift_r <= SHIFT_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MIN_SHIFT)
      shift_r <= cfg_pwdata[SHIFT_W-1:0];
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MIN_SHIFT) ? {{(32-SHIFT_W){1'b0}}, shift_r} : '0;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_datapath #(
    .TREE_LEVELS (TREE_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .min_shift   (shift_r),
    .in_kind     (in_tuser),
    .in_size     (in_tdata[26:0]),
    .in_offset   (in_tdata[36:27]),
    .out_status  (out_tuser),
    .out_granted (granted),
    .out_level   (level)
  );

  assign out_tdata = {2'b00, level, granted};

  // A taken request blocks the next one until it is done
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while one is in work");

  // Failed requests grant nothing
  a_size_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_SIZE |-> out_tdata[9:0] == 10'd0 && out_tdata[13:10] == 4'd0)
    else $error("oversize response carries a grant");

  a_oom_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_OOM |-> out_tdata[9:0] == 10'd0)
    else $error("out-of-memory response carries a grant");

endmodule
